// ===== design/fpa_pkg.sv =====
// Shared constants, opcodes and pipeline word types for the fixed-point ALU.
`default_nettype none

package fpa_pkg;

   localparam int DATA_W    = 32;
   localparam int FRAC_BITS = 8;
   // numerator of the divide is |a| shifted up by the fraction bits
   localparam int NUM_W     = DATA_W + FRAC_BITS;

   typedef enum logic [3:0] {
      KIND_ADD      = 4'd0,
      KIND_SUB      = 4'd1,
      KIND_MUL      = 4'd2,
      KIND_DIV      = 4'd3,
      KIND_MIN      = 4'd4,
      KIND_MAX      = 4'd5,
      KIND_INC      = 4'd6,
      KIND_DEC      = 4'd7,
      KIND_TO_INT   = 4'd8,
      KIND_FROM_INT = 4'd9
   } kind_type;

   // one word in flight through the divide pipeline
   typedef struct packed {
      logic              valid;
      logic              is_mul;
      logic              is_div;
      logic              neg;
      logic              dz;
      logic              lt;
      logic              eq;
      logic              gt;
      logic [DATA_W-1:0] res;
      logic [DATA_W-1:0] rem;
      logic [NUM_W-1:0]  nq;
      logic [DATA_W-1:0] dvs;
   } pipe_type;

   typedef struct packed {
      logic [DATA_W-1:0] res;
      logic              lt;
      logic              eq;
      logic              gt;
      logic              dz;
   } rsp_type;

endpackage

`default_nettype wire

// ===== design/fpa_div_step.sv =====
// One registered restoring-division step: one quotient bit per stage.
`default_nettype none

module fpa_div_step import fpa_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  pipe_type up_stage,
   output pipe_type down_stage
);

   logic [DATA_W:0]   shifted;
   logic [DATA_W+1:0] diff;
   logic              take;
   pipe_type          stage_in;
   pipe_type          stage_ff;

   assign shifted = {up_stage.rem, up_stage.nq[NUM_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, up_stage.dvs};
   assign take    = !diff[DATA_W+1];

   // remainder stays below the divisor, so it always fits in DATA_W bits
   always_comb begin
      stage_in     = up_stage;
      stage_in.rem = take ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
      stage_in.nq  = {up_stage.nq[NUM_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign down_stage = stage_ff;

endmodule

`default_nettype wire

// ===== design/fixed_point_alu_top.sv =====
// Top level of the pipelined Q24.8 fixed-point ALU.
//
// Request channel (req_*): opcode and two raw 32-bit operands, taken at a
// clock edge with req_valid high and req_stall low. Response channel (rsp_*):
// one word per request, in order, with the result, the signed compare flags
// of operand_a against operand_b and the divide-by-zero flag.
// Throughput is one word per cycle while req_stall is low. From acceptance
// to rsp_valid a word passes one input register, one decode stage, then one
// stage per quotient bit of the restoring divider, which every opcode passes
// through to keep order. The 32x32 multiply sits
// beside the first divider stage.
// A two-word output buffer parts the pipeline from the receiver: with one
// word waiting, the pipeline still moves and new requests are taken; only
// when both entries are held does req_stall rise and the pipeline freeze,
// losing nothing. Synchronous reset empties the pipeline and the buffer.
`default_nettype none

module fixed_point_alu_top import fpa_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [3:0]               req_kind,
   input  logic signed [DATA_W-1:0] req_operand_a,
   input  logic signed [DATA_W-1:0] req_operand_b,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_result,
   output logic                     rsp_is_less,
   output logic                     rsp_is_equal,
   output logic                     rsp_is_greater,
   output logic                     rsp_divide_by_zero
);

   logic                     advance;
   logic                     in_valid_ff;
   logic [3:0]               in_kind_ff;
   logic signed [DATA_W-1:0] in_a_ff;
   logic signed [DATA_W-1:0] in_b_ff;

   logic [DATA_W-1:0]        mag_a;
   logic [DATA_W-1:0]        mag_b;
   pipe_type                 prep_in;
   pipe_type                 prep_ff;

   logic [DATA_W-1:0]        mul_a;
   logic [DATA_W-1:0]        mul_b;
   logic [2*DATA_W-1:0]      prod_ff;

   pipe_type                 stage_d [0:NUM_W-1];
   pipe_type                 stage_q [0:NUM_W-1];
   pipe_type                 mul_fix;
   pipe_type                 last;

   logic [DATA_W-1:0]        mag_res;
   rsp_type                  push_word;
   logic                     push;
   logic                     pop;
   logic [1:0]               cnt_ff;
   logic [1:0]               cnt_in;
   rsp_type                  buf0_ff;
   rsp_type                  buf0_in;
   rsp_type                  buf1_ff;
   rsp_type                  buf1_in;

   // freeze only when both output entries are held
   assign advance   = (cnt_ff != 2'd2);
   assign req_stall = !advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_valid) begin
         in_kind_ff <= req_kind;
         in_a_ff    <= req_operand_a;
         in_b_ff    <= req_operand_b;
      end
   end

   // decode stage: magnitudes, flags and the results of every opcode but multiply and divide
   assign mag_a = in_a_ff[DATA_W-1] ? DATA_W'(-in_a_ff) : DATA_W'(in_a_ff);
   assign mag_b = in_b_ff[DATA_W-1] ? DATA_W'(-in_b_ff) : DATA_W'(in_b_ff);

   always_comb begin
      prep_in        = '0;
      prep_in.valid  = in_valid_ff;
      prep_in.is_mul = (in_kind_ff == KIND_MUL);
      prep_in.is_div = (in_kind_ff == KIND_DIV);
      prep_in.neg    = in_a_ff[DATA_W-1] ^ in_b_ff[DATA_W-1];
      prep_in.dz     = (in_kind_ff == KIND_DIV) && (in_b_ff == '0);
      prep_in.lt     = (in_a_ff < in_b_ff);
      prep_in.eq     = (in_a_ff == in_b_ff);
      prep_in.gt     = (in_a_ff > in_b_ff);
      prep_in.rem    = '0;
      prep_in.nq     = NUM_W'(mag_a) << FRAC_BITS;
      prep_in.dvs    = mag_b;
      unique case (in_kind_ff)
         KIND_ADD:      prep_in.res = DATA_W'(in_a_ff + in_b_ff);
         KIND_SUB:      prep_in.res = DATA_W'(in_a_ff - in_b_ff);
         KIND_MIN:      prep_in.res = (in_a_ff > in_b_ff) ? in_b_ff : in_a_ff;
         KIND_MAX:      prep_in.res = (in_a_ff > in_b_ff) ? in_a_ff : in_b_ff;
         KIND_INC:      prep_in.res = DATA_W'(in_a_ff + DATA_W'(1));
         KIND_DEC:      prep_in.res = DATA_W'(in_a_ff - DATA_W'(1));
         KIND_TO_INT:   prep_in.res = DATA_W'(in_a_ff >>> FRAC_BITS);
         KIND_FROM_INT: prep_in.res = DATA_W'(in_a_ff << FRAC_BITS);
         default:       prep_in.res = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_ff.valid <= 1'b0;
      end else if (advance) begin
         prep_ff <= prep_in;
      end
   end

   // magnitude multiply, alongside the first divider step
   assign mul_a = prep_ff.nq[NUM_W-1 -: DATA_W];
   assign mul_b = prep_ff.dvs;

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= mul_a * mul_b;
      end
   end

   always_comb begin
      mul_fix = stage_q[0];
      if (stage_q[0].is_mul) begin
         mul_fix.res = prod_ff[FRAC_BITS +: DATA_W];
      end
   end

   // divider pipeline, one quotient bit per stage
   genvar gi;
   generate
      for (gi = 0; gi < NUM_W; gi++) begin : g_step
         if (gi == 0) begin : g_first
            assign stage_d[gi] = prep_ff;
         end else if (gi == 1) begin : g_second
            assign stage_d[gi] = mul_fix;
         end else begin : g_rest
            assign stage_d[gi] = stage_q[gi-1];
         end
         fpa_div_step u_step (
            .clock      (clock),
            .reset      (reset),
            .en         (advance),
            .up_stage   (stage_d[gi]),
            .down_stage (stage_q[gi])
         );
      end
   endgenerate

   // sign fix-up of multiply and divide magnitudes; divide by zero gives a zero result
   assign last    = stage_q[NUM_W-1];
   assign mag_res = last.is_div ? last.nq[DATA_W-1:0] : last.res;

   always_comb begin
      push_word    = '0;
      push_word.lt = last.lt;
      push_word.eq = last.eq;
      push_word.gt = last.gt;
      push_word.dz = last.dz;
      if (last.dz) begin
         push_word.res = '0;
      end else if ((last.is_mul || last.is_div) && last.neg) begin
         push_word.res = DATA_W'(-mag_res);
      end else begin
         push_word.res = mag_res;
      end
   end

   // two-word output buffer, head in buf0
   assign push = advance && last.valid;
   assign pop  = (cnt_ff != 2'd0) && !rsp_stall;

   always_comb begin
      cnt_in  = cnt_ff;
      buf0_in = buf0_ff;
      buf1_in = buf1_ff;
      unique case ({push, pop})
         2'b11: begin
            buf0_in = push_word;
         end
         2'b10: begin
            if (cnt_ff == 2'd0) begin
               buf0_in = push_word;
            end else begin
               buf1_in = push_word;
            end
            cnt_in = cnt_ff + 2'd1;
         end
         2'b01: begin
            buf0_in = buf1_ff;
            cnt_in  = cnt_ff - 2'd1;
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      buf0_ff <= buf0_in;
      buf1_ff <= buf1_in;
   end

   assign rsp_valid          = (cnt_ff != 2'd0);
   assign rsp_result         = buf0_ff.res;
   assign rsp_is_less        = buf0_ff.lt;
   assign rsp_is_equal       = buf0_ff.eq;
   assign rsp_is_greater     = buf0_ff.gt;
   assign rsp_divide_by_zero = buf0_ff.dz;

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("output buffer count out of range");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && $past(cnt_ff) != 2'd0))
      else $error("request stalled with output buffer not full");

   a_flags_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot({rsp_is_less, rsp_is_equal, rsp_is_greater}))
      else $error("compare flags not one-hot");

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_divide_by_zero) |-> (rsp_result == '0))
      else $error("divide by zero with nonzero result");

endmodule

`default_nettype wire
